>>> sv/srvg_pkg.sv
// ----------------------------------------------------------------------------
// srvg_pkg: shared types and constants of the snapped ring vertex generator
// Fixed-point widths, CORDIC arctangent table, sequencer states and the
// status bundle returned by the iterative arithmetic units.
// ----------------------------------------------------------------------------
package srvg_pkg;

  localparam int COORD_BITS   = 24;
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int MAX_RING     = 24;

  localparam int RING_TOP     = 24;
  localparam int RING_DEFAULT = 6;
  localparam int RING_LIMIT   = (RING_TOP < MAX_RING) ? RING_TOP : MAX_RING;
  localparam int RING_W       = $clog2(MAX_RING + 1);
  localparam int SIZE_W       = 5;
  localparam int IDX_OUT_W    = 5;
  localparam int SECTORS      = 12;

  localparam int BOND_W       = 16;
  localparam logic [BOND_W-1:0] BOND_RESET = 16'd256;

  // CORDIC datapath: Q30 values with headroom, Q32-turn angle accumulator
  localparam int CW           = 34;
  localparam int CORDIC_GAIN  = 652032874;
  localparam int CIDX_W       = $clog2(CORDIC_STEPS);

  // restoring divider: numerator, divisor and quotient widths
  localparam int DIV_NUM_W    = 50;
  localparam int DIV_DEN_W    = 32;
  localparam int QUOT_BITS    = 24;
  localparam int REM_W        = DIV_DEN_W + QUOT_BITS;
  localparam int QIDX_W       = $clog2(QUOT_BITS);

  localparam int MUL_W        = 32;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_LUT [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ1,
    ST_SQ2,
    ST_SQ3,
    ST_SNAP,
    ST_SDIV_GO,
    ST_SDIV_WT,
    ST_SCOR_GO,
    ST_SCOR_WT,
    ST_ADIV_GO,
    ST_ADIV_WT,
    ST_VCOR_GO,
    ST_VCOR_WT,
    ST_MULX,
    ST_XDIV_GO,
    ST_XDIV_WT,
    ST_MULY,
    ST_YDIV_GO,
    ST_YDIV_WT,
    ST_EMIT
  } srvg_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } srvg_sts_t;

endpackage

>>> sv/srvg_if.sv
// ----------------------------------------------------------------------------
// srvg_in_if / srvg_out_if: valid/ready channels of the ring generator
// Input carries start point, drag point and ring size; output carries one
// vertex per transfer.
// ----------------------------------------------------------------------------
interface srvg_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [srvg_pkg::COORD_BITS-1:0] start_x;
  logic signed [srvg_pkg::COORD_BITS-1:0] start_y;
  logic signed [srvg_pkg::COORD_BITS-1:0] drag_x;
  logic signed [srvg_pkg::COORD_BITS-1:0] drag_y;
  logic        [srvg_pkg::SIZE_W-1:0]     ring_size;

  modport source (output valid, start_x, start_y, drag_x, drag_y, ring_size,
                  input ready);
  modport sink   (input valid, start_x, start_y, drag_x, drag_y, ring_size,
                  output ready);
endinterface

interface srvg_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [srvg_pkg::COORD_BITS-1:0] vertex_x;
  logic signed [srvg_pkg::COORD_BITS-1:0] vertex_y;
  logic        [srvg_pkg::IDX_OUT_W-1:0]  vertex_index;
  logic                                 last_vertex;

  modport source (output valid, vertex_x, vertex_y, vertex_index, last_vertex,
                  input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_index, last_vertex,
                  output ready);
endinterface

>>> sv/srvg_cordic.sv
// ----------------------------------------------------------------------------
// srvg_cordic: iterative CORDIC rotation, one step per cycle
// Converts a binary angle to cos and sin in Q30 after a quarter-turn
// reduction, starting from the converged gain.
// ----------------------------------------------------------------------------
module srvg_cordic (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [srvg_pkg::ANGLE_BITS-1:0]     bam,
  output logic signed [srvg_pkg::CW-1:0]      cos_o,
  output logic signed [srvg_pkg::CW-1:0]      sin_o,
  output srvg_pkg::srvg_sts_t                 sts
);
  import srvg_pkg::*;

  logic signed [CW-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [1:0]           q_r;
  logic [CIDX_W-1:0]    idx_r;
  logic                 busy_r, done_r;
  logic [31:0]          ang, ang_off, ang_red;
  logic [1:0]           quad;
  logic signed [CW-1:0] x_sh, y_sh, atan_v;

  // reduce the angle to within an eighth turn of an axis
  always_comb begin
    ang     = {bam, (32 - ANGLE_BITS)'(0)};
    ang_off = ang + 32'h2000_0000;
    quad    = ang_off[31:30];
    ang_red = ang - {quad, 30'd0};
  end

  // one rotation step
  always_comb begin
    x_sh   = x_r >>> idx_r;
    y_sh   = y_r >>> idx_r;
    atan_v = $signed({(CW - 32)'(0), ATAN_LUT[idx_r]});
    if (z_r >= 0) begin
      x_nxt = x_r - y_sh;
      y_nxt = y_r + x_sh;
      z_nxt = z_r - atan_v;
    end else begin
      x_nxt = x_r + y_sh;
      y_nxt = y_r - x_sh;
      z_nxt = z_r + atan_v;
    end
  end

  // control: load on start, iterate, pulse done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (busy_r) begin
        if (idx_r == CIDX_W'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= CW'(CORDIC_GAIN);
      y_r <= '0;
      z_r <= CW'($signed(ang_red));
      q_r <= quad;
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  // map back to the original quadrant
  always_comb begin
    case (q_r)
      2'd0: begin cos_o = x_r;  sin_o = y_r;  end
      2'd1: begin cos_o = -y_r; sin_o = x_r;  end
      2'd2: begin cos_o = -x_r; sin_o = -y_r; end
      default: begin cos_o = y_r; sin_o = -x_r; end
    endcase
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

>>> sv/srvg_div.sv
// ----------------------------------------------------------------------------
// srvg_div: restoring unsigned divider, one quotient bit per cycle
// Quotient is known to fit in QUOT_BITS bits for every use in the block.
// ----------------------------------------------------------------------------
module srvg_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [srvg_pkg::DIV_NUM_W-1:0]      num,
  input  logic [srvg_pkg::DIV_DEN_W-1:0]      den,
  output logic [srvg_pkg::QUOT_BITS-1:0]      quot,
  output srvg_pkg::srvg_sts_t                 sts
);
  import srvg_pkg::*;

  logic [REM_W-1:0]     rem_r, dsh_r;
  logic [QUOT_BITS-1:0] q_r;
  logic [QIDX_W-1:0]    cnt_r;
  logic                 busy_r, done_r;
  logic                 fits;

  assign fits = (rem_r >= dsh_r);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == QIDX_W'(QUOT_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // subtract the shifted divisor where it fits
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= REM_W'(num);
      dsh_r <= {den, (QUOT_BITS - 1)'(0), 1'b0} >> 1;
      q_r   <= '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - dsh_r;
      end
      q_r   <= {q_r[QUOT_BITS-2:0], fits};
      dsh_r <= dsh_r >> 1;
    end
  end

  assign quot     = q_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

>>> sv/snapped_ring_vertex_generator.sv
// ----------------------------------------------------------------------------
// snapped_ring_vertex_generator: regular ring placed along a snapped drag
// Setup takes one division and one CORDIC rotation; each vertex then takes
// three divisions on the shared divider (one quotient bit per cycle) and one
// CORDIC rotation (one step per cycle).
// One item at a time: in_ch.ready is high only while the sequencer is idle.
// Reset (rst_n low, synchronous) idles the sequencer, drops any pending
// vertex and sets bond_length to 256.
// ----------------------------------------------------------------------------
module snapped_ring_vertex_generator (
  input  logic                          clk,
  input  logic                          rst_n,
  srvg_in_if.sink                       in_ch,
  srvg_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [srvg_pkg::BOND_W-1:0]   cfg_wdata
);
  import srvg_pkg::*;

  localparam int DW  = COORD_BITS + 1;
  localparam int AW  = COORD_BITS;
  localparam int TW  = AW + 3;
  localparam int ANG_W = 12;
  localparam int SW  = COORD_BITS + 3;

  srvg_state_t state_r, state_nxt;

  logic [BOND_W-1:0]         bond_r;
  logic signed [COORD_BITS-1:0] sx_r, sy_r;
  logic [AW-1:0]             a_r, b_r;
  logic                      dx_neg_r, dx_pos_r, dy_neg_r;
  logic [RING_W-1:0]         n_r, n_nxt;
  logic [3:0]                km_r, km_nxt;
  logic [RING_W-1:0]         i_r;
  logic [63:0]               prod_r, p1_r, aa_r;
  logic [DIV_DEN_W-1:0]      den_r;
  logic signed [CW-1:0]      ux_r, uy_r, vx_r, vy_r;
  logic                      sgnx_r;
  logic [QUOT_BITS-1:0]      qx_r;

  logic signed [DW-1:0]      dx, dy;
  logic signed [TW-1:0]      t1, t2;
  logic [63:0]               three_aa;
  logic [2:0]                fsec, msec;
  logic signed [CW:0]        diffx, diffy;
  logic [MUL_W-1:0]          absx, absy;
  logic [MUL_W-1:0]          mul_a, mul_b;
  logic [ANG_W-1:0]          ang_turn;
  logic                      last_i;

  logic                      div_start, cor_start;
  logic [DIV_NUM_W-1:0]      div_num;
  logic [DIV_DEN_W-1:0]      div_den;
  logic [QUOT_BITS-1:0]      div_quot;
  srvg_sts_t                 div_sts, cor_sts;
  logic [ANGLE_BITS-1:0]     cor_bam;
  logic signed [CW-1:0]      cor_cos, cor_sin;
  logic signed [CW:0]        sin2;

  logic                      in_fire, out_free, emit_load;
  logic signed [SW-1:0]      px, py;
  logic signed [SW-1:0]      sq;

  logic                      out_valid_r;
  logic signed [COORD_BITS-1:0] vx_out_r, vy_out_r;
  logic [IDX_OUT_W-1:0]      idx_out_r;
  logic                      last_out_r;

  // shared units
  srvg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (div_quot),
    .sts   (div_sts)
  );

  srvg_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .bam   (cor_bam),
    .cos_o (cor_cos),
    .sin_o (cor_sin),
    .sts   (cor_sts)
  );

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign last_i   = (i_r == n_r - 1'b1);

  // drag vector and ring size from the input fields
  always_comb begin
    dx = DW'(in_ch.drag_x) - DW'(in_ch.start_x);
    dy = DW'(in_ch.drag_y) - DW'(in_ch.start_y);
    if (in_ch.ring_size inside {[3:RING_LIMIT]}) begin
      n_nxt = RING_W'(in_ch.ring_size);
    end else begin
      n_nxt = RING_W'(RING_DEFAULT);
    end
  end

  // sector decision terms
  always_comb begin
    t1       = $signed({2'b0, a_r, 1'b0}) - $signed({3'b0, b_r});
    t2       = $signed({3'b0, b_r}) - $signed({2'b0, a_r, 1'b0});
    three_aa = aa_r + (aa_r << 1);
    if (t1 > 0 && p1_r > three_aa) begin
      fsec = 3'd0;
    end else if (b_r < a_r) begin
      fsec = 3'd1;
    end else if (b_r == a_r) begin
      fsec = dx_pos_r ? 3'd2 : 3'd1;
    end else if (t2 > 0 && prod_r > three_aa) begin
      fsec = 3'd3;
    end else begin
      fsec = 3'd2;
    end
    msec = dx_neg_r ? 3'd6 - fsec : fsec;
    if (a_r < AW'(3) && b_r < AW'(3)) begin
      km_nxt = 4'd0;
    end else if (dy_neg_r && msec != 3'd0) begin
      km_nxt = 4'(SECTORS) - 4'(msec);
    end else begin
      km_nxt = 4'(msec);
    end
  end

  // unit vector differences and vertex angle numerator
  always_comb begin
    diffx    = (CW + 1)'(ux_r) - (CW + 1)'(vx_r);
    diffy    = (CW + 1)'(uy_r) - (CW + 1)'(vy_r);
    absx     = diffx[CW] ? MUL_W'(-diffx) : MUL_W'(diffx);
    absy     = diffy[CW] ? MUL_W'(-diffy) : MUL_W'(diffy);
    ang_turn = ANG_W'(km_r) * ANG_W'(n_r) + ANG_W'(i_r) * ANG_W'(SECTORS);
    sin2     = (CW + 1)'(cor_sin) <<< 1;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_fire) state_nxt = ST_SQ1;
      ST_SQ1:     state_nxt = ST_SQ2;
      ST_SQ2:     state_nxt = ST_SQ3;
      ST_SQ3:     state_nxt = ST_SNAP;
      ST_SNAP:    state_nxt = ST_SDIV_GO;
      ST_SDIV_GO: state_nxt = ST_SDIV_WT;
      ST_SDIV_WT: if (div_sts.done) state_nxt = ST_SCOR_GO;
      ST_SCOR_GO: state_nxt = ST_SCOR_WT;
      ST_SCOR_WT: if (cor_sts.done) state_nxt = ST_ADIV_GO;
      ST_ADIV_GO: state_nxt = ST_ADIV_WT;
      ST_ADIV_WT: if (div_sts.done) state_nxt = ST_VCOR_GO;
      ST_VCOR_GO: state_nxt = ST_VCOR_WT;
      ST_VCOR_WT: if (cor_sts.done) state_nxt = ST_MULX;
      ST_MULX:    state_nxt = ST_XDIV_GO;
      ST_XDIV_GO: state_nxt = ST_XDIV_WT;
      ST_XDIV_WT: if (div_sts.done) state_nxt = ST_MULY;
      ST_MULY:    state_nxt = ST_YDIV_GO;
      ST_YDIV_GO: state_nxt = ST_YDIV_WT;
      ST_YDIV_WT: if (div_sts.done) state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_nxt = last_i ? ST_IDLE : ST_ADIV_GO;
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // unit commands and multiplier operands
  always_comb begin
    div_start = 1'b0;
    cor_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    cor_bam   = div_quot[ANGLE_BITS-1:0];
    mul_a     = '0;
    mul_b     = '0;
    emit_load = 1'b0;
    case (state_r)
      ST_SQ1: begin
        mul_a = (t1 > 0) ? MUL_W'(t1) : '0;
        mul_b = mul_a;
      end
      ST_SQ2: begin
        mul_a = MUL_W'(a_r);
        mul_b = MUL_W'(a_r);
      end
      ST_SQ3: begin
        mul_a = (t2 > 0) ? MUL_W'(t2) : '0;
        mul_b = mul_a;
      end
      ST_SDIV_GO: begin
        div_start = 1'b1;
        div_num   = DIV_NUM_W'(1 << ANGLE_BITS) + DIV_NUM_W'(n_r);
        div_den   = DIV_DEN_W'(n_r) << 1;
      end
      ST_SCOR_GO, ST_VCOR_GO: cor_start = 1'b1;
      ST_ADIV_GO: begin
        div_start = 1'b1;
        div_num   = (DIV_NUM_W'(ang_turn) << ANGLE_BITS)
                    + DIV_NUM_W'(n_r) * DIV_NUM_W'(SECTORS / 2);
        div_den   = DIV_DEN_W'(n_r) * DIV_DEN_W'(SECTORS);
      end
      ST_MULX: begin
        mul_a = MUL_W'(bond_r);
        mul_b = absx;
      end
      ST_MULY: begin
        mul_a = MUL_W'(bond_r);
        mul_b = absy;
      end
      ST_XDIV_GO, ST_YDIV_GO: begin
        div_start = 1'b1;
        div_num   = DIV_NUM_W'(prod_r) + DIV_NUM_W'(den_r >> 1);
        div_den   = den_r;
      end
      ST_EMIT: emit_load = out_free;
      default: ;
    endcase
  end

  // signed offsets added to the start point, then saturate
  always_comb begin
    sq = sgnx_r ? -SW'(qx_r) : SW'(qx_r);
    px = SW'(sx_r) + sq;
    sq = diffy[CW] ? -SW'(div_quot) : SW'(div_quot);
    py = SW'(sy_r) + sq;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      bond_r      <= BOND_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        bond_r <= cfg_wdata;
      end
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
    if (in_fire) begin
      sx_r     <= in_ch.start_x;
      sy_r     <= in_ch.start_y;
      a_r      <= dx[DW-1] ? AW'(-dx) : AW'(dx);
      b_r      <= dy[DW-1] ? AW'(-dy) : AW'(dy);
      dx_neg_r <= dx[DW-1];
      dx_pos_r <= !dx[DW-1] && (dx != '0);
      dy_neg_r <= dy[DW-1];
      n_r      <= n_nxt;
    end
    case (state_r)
      ST_SQ2:  p1_r <= prod_r;
      ST_SQ3:  aa_r <= prod_r;
      ST_SNAP: km_r <= km_nxt;
      ST_SCOR_WT: begin
        if (cor_sts.done) begin
          den_r <= (cor_sin <= 0) ? DIV_DEN_W'(1) : DIV_DEN_W'(sin2);
          i_r   <= '0;
        end
      end
      ST_VCOR_WT: begin
        if (cor_sts.done) begin
          vx_r <= cor_cos;
          vy_r <= cor_sin;
          if (i_r == '0) begin
            ux_r <= cor_cos;
            uy_r <= cor_sin;
          end
        end
      end
      ST_XDIV_GO: sgnx_r <= diffx[CW];
      ST_XDIV_WT: if (div_sts.done) qx_r <= div_quot;
      ST_EMIT: begin
        if (out_free) i_r <= i_r + 1'b1;
      end
      default: ;
    endcase
    if (emit_load) begin
      vx_out_r   <= (px > SW'((1 << (COORD_BITS - 1)) - 1)) ?
                    COORD_BITS'((1 << (COORD_BITS - 1)) - 1) :
                    (px < -SW'(1 << (COORD_BITS - 1))) ?
                    COORD_BITS'(-(1 << (COORD_BITS - 1))) : COORD_BITS'(px);
      vy_out_r   <= (py > SW'((1 << (COORD_BITS - 1)) - 1)) ?
                    COORD_BITS'((1 << (COORD_BITS - 1)) - 1) :
                    (py < -SW'(1 << (COORD_BITS - 1))) ?
                    COORD_BITS'(-(1 << (COORD_BITS - 1))) : COORD_BITS'(py);
      idx_out_r  <= IDX_OUT_W'(i_r);
      last_out_r <= last_i;
    end
  end

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.vertex_x     = vx_out_r;
  assign out_ch.vertex_y     = vy_out_r;
  assign out_ch.vertex_index = idx_out_r;
  assign out_ch.last_vertex  = last_out_r;

endmodule

>>> sv/srvg_checker.sv
// ----------------------------------------------------------------------------
// srvg_checker: port-level checks of the ring generator
// Watches the channel ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module srvg_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [srvg_pkg::COORD_BITS-1:0] vertex_x,
  input logic [srvg_pkg::IDX_OUT_W-1:0]      vertex_index,
  input logic                                last_vertex
);
  import srvg_pkg::*;

  // an accepted item keeps the input side closed for the next cycle
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  // vertex index stays inside the largest ring
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> vertex_index < IDX_OUT_W'(MAX_RING))
    else $error("vertex index beyond ring");

  // a ring closes after at least three vertices
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && last_vertex |-> vertex_index >= IDX_OUT_W'(2))
    else $error("ring closed too early");

  // a stalled vertex holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(vertex_x))
    else $error("stalled vertex changed");

endmodule

bind snapped_ring_vertex_generator srvg_checker u_srvg_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .vertex_x     (out_ch.vertex_x),
  .vertex_index (out_ch.vertex_index),
  .last_vertex  (out_ch.last_vertex)
);

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the snapped ring vertex generator
// Drives start/drag/size items through the valid/ready input, predicts every
// vertex with a bit-accurate CORDIC model, and checks each vertex transfer in
// order. Covers several edge lengths, random idling on both sides, a long
// output hold-off and a drain between phases.
// ----------------------------------------------------------------------------
module tb;
  import srvg_pkg::*;

  typedef struct {
    logic signed [COORD_BITS-1:0] vx;
    logic signed [COORD_BITS-1:0] vy;
    logic [IDX_OUT_W-1:0]         vidx;
    logic                         vlast;
  } vertex_t;

  // Vertex predictor and in-order store of expected vertices
  class ring_scoreboard;
    vertex_t     pending[$];
    logic [15:0] bond_len;
    int          failures;
    int          rings_seen;
    int          vertices_seen;

    function new();
      bond_len = BOND_RESET;
    endfunction

    // Q30 cos/sin of a 16-bit binary angle
    function automatic void unit_q30(input longint unsigned bam,
                                     output longint c, output longint s);
      logic [31:0] a, q, r;
      longint z, x, y, nx;
      a = {bam[15:0], 16'h0};
      q = ((a + 32'h2000_0000) >> 30) & 32'd3;
      r = a - (q << 30);
      z = longint'($signed(r));
      x = CORDIC_GAIN;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i); y = y + (x >>> i); z -= longint'(ATAN_LUT[i]);
        end else begin
          nx = x + (y >>> i); y = y - (x >>> i); z += longint'(ATAN_LUT[i]);
        end
        x = nx;
      end
      case (q[1:0])
        2'd0: begin c = x;  s = y;  end
        2'd1: begin c = -y; s = x;  end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    // Sector -6..6 of the drag vector, multiples of 30 degrees
    function automatic int snap_sector(longint dx, longint dy);
      longint a, b, t;
      int f, m;
      a = dx < 0 ? -dx : dx;
      b = dy < 0 ? -dy : dy;
      if (a * 100 < 256 && b * 100 < 256) return 0;
      t = 2 * a - b;
      if (t > 0 && t * t > 3 * a * a) f = 0;
      else if (b < a) f = 1;
      else if (b == a) f = (dx > 0) ? 2 : 1;
      else begin
        t = b - 2 * a;
        f = (t > 0 && t * t > 3 * a * a) ? 3 : 2;
      end
      m = (dx >= 0) ? f : 6 - f;
      return (dy < 0) ? -m : m;
    endfunction

    function automatic longint round_div(longint num, longint den);
      longint unsigned n, q;
      n = num < 0 ? -num : num;
      q = (n + den / 2) / den;
      return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp(longint v);
      longint hi, lo;
      hi = (longint'(1) << (COORD_BITS - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    // Note an accepted item: queue its whole ring of vertices
    function automatic void note_ring(logic signed [23:0] sx24, logic signed [23:0] sy24,
                                      logic signed [23:0] dx24, logic signed [23:0] dy24,
                                      logic [4:0] size);
      longint sx, sy, dx, dy, sc, sn, den, ux, uy, vx, vy;
      longint unsigned n, km, full, bam;
      int k;
      vertex_t v;
      sx = sx24; sy = sy24;
      dx = longint'(dx24) - sx;
      dy = longint'(dy24) - sy;
      full = 1 << ANGLE_BITS;
      k = snap_sector(dx, dy);
      n = (size >= 3 && size <= RING_LIMIT) ? size : RING_DEFAULT;
      km = (k < 0) ? k + 12 : k;
      unit_q30((full + n) / (2 * n), sc, sn);
      den = 2 * sn;
      if (den < 1) den = 1;
      unit_q30((km * n * full + 6 * n) / (12 * n), ux, uy);
      for (longint unsigned i = 0; i < n; i++) begin
        bam = ((km * n + 12 * i) * full + 6 * n) / (12 * n);
        unit_q30(bam, vx, vy);
        v.vx = clamp(sx + round_div(longint'(bond_len) * (ux - vx), den));
        v.vy = clamp(sy + round_div(longint'(bond_len) * (uy - vy), den));
        v.vidx = i[4:0];
        v.vlast = (i + 1 == n);
        pending.push_back(v);
      end
      rings_seen++;
    endfunction

    // Compare one vertex transfer with the oldest expectation
    function automatic void check_vertex(vertex_t got);
      vertex_t exp_v;
      vertices_seen++;
      if (pending.size() == 0) begin
        $error("unexpected vertex x=%0d y=%0d index=%0d", got.vx, got.vy, got.vidx);
        failures++;
        return;
      end
      exp_v = pending.pop_front();
      if (got.vx !== exp_v.vx) begin
        $error("vertex_x expected %0d got %0d", exp_v.vx, got.vx); failures++;
      end
      if (got.vy !== exp_v.vy) begin
        $error("vertex_y expected %0d got %0d", exp_v.vy, got.vy); failures++;
      end
      if (got.vidx !== exp_v.vidx) begin
        $error("vertex_index expected %0d got %0d", exp_v.vidx, got.vidx); failures++;
      end
      if (got.vlast !== exp_v.vlast) begin
        $error("last_vertex expected %0d got %0d", exp_v.vlast, got.vlast); failures++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  srvg_in_if  in_if();
  srvg_out_if out_if();

  snapped_ring_vertex_generator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ring_scoreboard sb = new();

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  bit holdoff_req  = 1'b0;
  int quiet_cycles = 0;

  localparam int QUIET_LIMIT   = 20000;
  localparam int HOLDOFF_CYCLES = 4000;

  always #5 clk = ~clk;

  initial begin
    in_if.valid     = 1'b0;
    in_if.start_x   = '0;
    in_if.start_y   = '0;
    in_if.drag_x    = '0;
    in_if.drag_y    = '0;
    in_if.ring_size = '0;
    out_if.ready    = 1'b0;
  end

  // Drive output ready: random stalls, plus one long hold-off on request
  always begin
    @(negedge clk);
    if (holdoff_req) begin
      out_if.ready = 1'b0;
      for (int c = 0; c < HOLDOFF_CYCLES; c++) @(negedge clk);
      holdoff_req = 1'b0;
    end
    out_if.ready = ($urandom_range(99) >= snk_idle_pct);
  end

  // Check each vertex transfer; track quiet cycles for the watchdog
  always @(posedge clk) begin
    vertex_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.vx = out_if.vertex_x;
      got.vy = out_if.vertex_y;
      got.vidx = out_if.vertex_index;
      got.vlast = out_if.last_vertex;
      sb.check_vertex(got);
    end
    if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  always @(posedge clk) begin
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offer one item and hold it until the transfer
  task automatic send_ring(logic [23:0] sx, logic [23:0] sy, logic [23:0] dx,
                           logic [23:0] dy, logic [4:0] size);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.start_x   = sx;
    in_if.start_y   = sy;
    in_if.drag_x    = dx;
    in_if.drag_y    = dy;
    in_if.ring_size = size;
    in_if.valid     = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    sb.note_ring(sx, sy, dx, dy, size);
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  // Pause the sender until every queued vertex has come back
  task automatic drain();
    in_if.valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_bond(logic [15:0] value);
    cfg_wdata = value;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
    sb.bond_len = value;
  endtask

  // Random ring size: mostly valid sizes, small ones favored
  function automatic logic [4:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 55) return $urandom_range(3, 10);
    if (r < 70) return $urandom_range(11, 24);
    return $urandom_range(31);
  endfunction

  task automatic send_random();
    logic [23:0] sx, sy, dx, dy;
    int sel, a;
    sel = $urandom_range(99);
    sx = $urandom;
    sy = $urandom;
    if (sel < 45) begin
      // modest drag around a moderate start point
      sx = $signed(24'($urandom_range(65535))) - 24'sd32768;
      sy = $signed(24'($urandom_range(65535))) - 24'sd32768;
      dx = sx + $signed(24'($urandom_range(8191))) - 24'sd4096;
      dy = sy + $signed(24'($urandom_range(8191))) - 24'sd4096;
    end else if (sel < 65) begin
      // exact diagonal or axis drag
      a = $urandom_range(1, 5000);
      dx = sx + (($urandom_range(1)) ? a : -a) * $urandom_range(1);
      dy = sy + (($urandom_range(1)) ? a : -a) * $urandom_range(1);
    end else if (sel < 75) begin
      // short drag near the dead zone
      dx = sx + $signed(24'($urandom_range(6))) - 24'sd3;
      dy = sy + $signed(24'($urandom_range(6))) - 24'sd3;
    end else begin
      dx = $urandom;
      dy = $urandom;
    end
    send_ring(sx, sy, dx, dy, pick_size());
  endtask

  task automatic run_random(int count);
    for (int j = 0; j < count; j++) send_random();
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: snap directions, dead zone, sizes, saturation
    src_idle_pct = 6;
    snk_idle_pct = 54;
    send_ring(24'd0, 24'd0, 24'd1000, 24'd0, 5'd6);
    send_ring(24'd0, 24'd0, -24'sd1000, 24'd0, 5'd6);
    send_ring(24'd0, 24'd0, 24'd0, 24'd1000, 5'd4);
    send_ring(24'd0, 24'd0, 24'd0, -24'sd1000, 5'd5);
    send_ring(24'd100, 24'd100, 24'd600, 24'd600, 5'd3);
    send_ring(24'd100, 24'd100, 24'd600, -24'sd400, 5'd6);
    send_ring(24'd100, 24'd100, -24'sd400, 24'd600, 5'd6);
    send_ring(24'd100, 24'd100, -24'sd400, -24'sd400, 5'd8);
    send_ring(24'd50, 24'd50, 24'd52, 24'd48, 5'd6);
    send_ring(24'd50, 24'd50, 24'd53, 24'd50, 5'd6);
    send_ring(24'd0, 24'd0, 24'd173, 24'd100, 5'd12);
    send_ring(24'd0, 24'd0, 24'd100, 24'd173, 5'd24);
    send_ring(24'd0, 24'd0, 24'd500, 24'd1, 5'd0);
    send_ring(24'd0, 24'd0, 24'd500, 24'd1, 5'd2);
    send_ring(24'd0, 24'd0, 24'd500, 24'd1, 5'd25);
    send_ring(24'd0, 24'd0, 24'd500, 24'd1, 5'd31);
    send_ring(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 5'd6);
    send_ring(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 5'd6);
    send_ring(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 5'd7);

    // Long output hold-off while the sender keeps offering
    holdoff_req = 1'b1;
    run_random(8);
    drain();

    write_bond(16'hFFFF);
    send_ring(24'd0, 24'd0, 24'd1000, 24'd0, 5'd3);
    send_ring(24'h7F0000, 24'h7F0000, 24'h7F1000, 24'h7F0000, 5'd6);
    run_random(80);
    drain();

    src_idle_pct = 54;
    snk_idle_pct = 6;
    write_bond(16'd1);
    run_random(30);
    drain();
    write_bond(16'd0);
    send_ring(24'd1234, -24'sd77, 24'd5000, 24'd9000, 5'd9);
    run_random(20);
    drain();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_bond($urandom_range(2, 65534));
    run_random(60);
    drain();
    write_bond(16'd256);
    run_random(60);
    drain();
    repeat (200) @(negedge clk);

    $display("Covered %0d rings and %0d vertices over edge lengths 0, 1, 256, 65535 and random,",
             sb.rings_seen, sb.vertices_seen);
    $display("with both-side stalls, a long output hold-off and drains between phases.");
    if (sb.failures == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (sb.pending.size() != 0) $error("%0d vertices never arrived", sb.pending.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
